// ===== design/wtsl_pkg.sv =====
// Shared types and constants for the waypoint twist slew limiter.
// No dependencies; every other file of the block but wtsl_ram imports this package.
package wtsl_pkg;

    // Default size of the waypoint table
    localparam int unsigned MAX_WAYPOINTS_DEF = 16;

    // Milli scaling: round-half-up of v / 1000, done as (v + 500) * RECIP >> SHIFT.
    // The reciprocal is exact for every 32-bit operand.
    localparam logic [31:0] MILLI_RECIP = 32'h1062_4DD3;
    localparam int unsigned MILLI_SHIFT = 38;
    localparam logic [31:0] MILLI_ROUND = 32'd500;

    // Field widths fixed by the interface
    localparam int unsigned CFG_W   = 31;
    localparam int unsigned COORD_W = 32;
    localparam int unsigned DIVQ_W  = 31;
    localparam int unsigned DIVN_W  = 63;

    // Request actions
    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_LOAD    = 2'd1,
        ACT_RESTART = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_PATH_SPEED  = 2'd0,
        CFG_TRANS_ACCEL = 2'd1,
        CFG_ROT_ACCEL   = 2'd2,
        CFG_WP_COUNT    = 2'd3
    } t_cfg_index;

    // Tick sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_RDA,
        S_RDB,
        S_DIFF,
        S_SQ_MUL,
        S_SQ_ACC,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_MILLI_MUL,
        S_MILLI_SCALE,
        S_VEL_MUL,
        S_VEL_GO,
        S_VEL_WAIT,
        S_FIN
    } t_state;

    // Divider request
    typedef struct packed {
        logic                start;
        logic [DIVN_W-1:0]   dividend;
        logic [31:0]         divisor;
    } t_div_req;

endpackage

// ===== design/wtsl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wtsl_ram #(
    parameter int unsigned WIDTH = 96,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/wtsl_div.sv =====
// Restoring divider, one quotient bit per cycle, 31 quotient bits.
// Depends on wtsl_pkg. Caller guarantees dividend >> 31 < divisor.
module wtsl_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  wtsl_pkg::t_div_req       i_req,
    output logic                     o_done,
    output logic [wtsl_pkg::DIVQ_W-1:0] o_quot
);
    import wtsl_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [4:0]        r_cnt, n_cnt;
    logic [31:0]       r_rem, n_rem;
    logic [DIVQ_W-1:0] r_low, n_low;
    logic [31:0]       r_div, n_div;
    logic [32:0]       trial;
    logic              ge;

    // One restoring step
    always_comb begin
        trial  = {r_rem, r_low[DIVQ_W-1]};
        ge     = trial >= {1'b0, r_div};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_low  = r_low;
        n_div  = r_div;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = i_req.dividend[DIVN_W-1:DIVQ_W];
            n_low  = i_req.dividend[DIVQ_W-1:0];
            n_div  = i_req.divisor;
        end else if (r_busy) begin
            n_rem = ge ? 32'(trial - {1'b0, r_div}) : trial[31:0];
            n_low = {r_low[DIVQ_W-2:0], ge};
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'(DIVQ_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_low <= n_low;
        r_div <= n_div;
    end

    assign o_done = r_done;
    assign o_quot = r_low;
endmodule

// ===== design/wtsl_sqrt.sv =====
// Integer square root of a 64-bit value, one result bit per cycle.
// Depends on wtsl_pkg.
module wtsl_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_value,
    output logic        o_done,
    output logic [31:0] o_root
);
    import wtsl_pkg::*;

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [4:0]  r_cnt, n_cnt;
    logic [63:0] r_x, n_x;
    logic [34:0] r_rem, n_rem;
    logic [31:0] r_root, n_root;
    logic [34:0] rem_sh;
    logic [34:0] trial;
    logic        ge;

    // Bring down two bits, try root*4+1
    always_comb begin
        rem_sh = {r_rem[32:0], r_x[63:62]};
        trial  = {1'b0, r_root, 2'b01};
        ge     = rem_sh >= trial;
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_x    = r_x;
        n_rem  = r_rem;
        n_root = r_root;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_x    = i_value;
            n_rem  = '0;
            n_root = '0;
        end else if (r_busy) begin
            n_x    = {r_x[61:0], 2'b00};
            n_rem  = ge ? rem_sh - trial : rem_sh;
            n_root = {r_root[30:0], ge};
            n_cnt  = r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_x    <= n_x;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

// ===== design/waypoint_twist_slew_limiter_unit.sv =====
// Top level of the waypoint twist slew limiter: sequencer, waypoint RAM,
// shared multiplier, divider and square root. Depends on wtsl_pkg and all wtsl_* modules.
//
// Usage:
//   Input channel (i_valid/o_ready) carries requests: load a waypoint row,
//   restart the path, or one control tick. Output channel (o_valid/i_ready)
//   carries one result per tick. Configuration is a plain write port
//   (i_cfg_we, i_cfg_index, i_cfg_data); the user must see that it is written only
//   while the block is idle, as the block does not enforce this. Load, restart and
//   unknown actions finish in the cycle of acceptance. A tick runs through two RAM
//   reads and the differences, three squares on the shared multiplier, a
//   32-step square root, three milli scalings by reciprocal multiply, then
//   three 31-step divisions for the axis velocities, each preceded by a
//   multiply. A zero-length segment skips the divisions; a squared length
//   of 2^64 or more skips the root. The block is not ready while a tick is
//   in flight. The result sits in an output register; the next request
//   is taken while it waits, but a following tick holds in its last step
//   until the receiver takes the earlier result.
//   Reset (synchronous, active low) zeroes limits, position, segment and
//   velocity history and sets the waypoint count to two; the waypoint RAM
//   is not cleared, and slots must be loaded before use.
module waypoint_twist_slew_limiter_unit #(
    parameter int unsigned MAX_WAYPOINTS = wtsl_pkg::MAX_WAYPOINTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic [3:0]  i_wp_index,
    input  logic signed [31:0] i_wp_x,
    input  logic signed [31:0] i_wp_y,
    input  logic signed [31:0] i_wp_z,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [31:0] o_vel_x,
    output logic signed [31:0] o_vel_y,
    output logic signed [31:0] o_vel_z,
    output logic signed [31:0] o_rate_x,
    output logic signed [31:0] o_rate_y,
    output logic signed [31:0] o_rate_z,
    output logic [3:0]  o_segment,
    output logic        o_path_done,
    output logic        o_zero_segment,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [wtsl_pkg::CFG_W-1:0] i_cfg_data
);
    import wtsl_pkg::*;

    localparam int unsigned SEG_W = $clog2(MAX_WAYPOINTS);
    localparam int unsigned ROW_W = 3 * COORD_W;

    // Slew one value toward its target by at most lim
    function automatic logic [31:0] slew(input logic [31:0] target,
                                         input logic [31:0] last,
                                         input logic [31:0] lim);
        logic [33:0] diff;
        logic [33:0] mag;
        logic [31:0] res;
        diff = {{2{target[31]}}, target} - {{2{last[31]}}, last};
        mag  = diff[33] ? 34'(-diff) : diff;
        if (mag > {2'b00, lim}) begin
            res = diff[33] ? last - lim : last + lim;
        end else begin
            res = target;
        end
        return res;
    endfunction

    t_state r_state, n_state;

    // Configuration
    logic [CFG_W-1:0] r_speed, r_taccel, r_raccel;
    logic [4:0]       r_count;

    // Path state
    logic [SEG_W-1:0] r_seg;
    logic [31:0]      r_pos;
    logic [31:0]      r_lastv [3];
    logic [31:0]      r_lastr [3];

    // Tick working registers
    logic [1:0]       r_ax;
    logic [ROW_W-1:0] r_wa;
    logic [31:0]      r_mag [3];
    logic             r_neg [3];
    logic [63:0]      r_prod;
    logic [65:0]      r_sum;
    logic [31:0]      r_len;
    logic [31:0]      r_step, r_tlim, r_rlim;
    logic [31:0]      r_target [3];

    // Output register
    logic             r_out_valid;
    logic [31:0]      r_ovel [3];
    logic [31:0]      r_orate [3];
    logic [3:0]       r_oseg;
    logic             r_odone, r_ozero;

    // Units and control
    logic [SEG_W-1:0] ram_raddr;
    logic [ROW_W-1:0] ram_rdata;
    logic             ram_we;
    t_div_req         div_req;
    logic             div_done;
    logic [DIVQ_W-1:0] div_quot;
    logic             sqrt_start, sqrt_done;
    logic [31:0]      sqrt_root;
    logic [31:0]      mul_a;
    logic [31:0]      mul_b;
    logic [63:0]      mul_p;
    logic [31:0]      milli_src;

    logic             in_acc;
    logic [31:0]      cnt_cl;
    logic [SEG_W-1:0] last_seg;
    logic             len_zero, sum_ovf, out_free;
    logic [32:0]      pos_sum;
    logic [31:0]      pos_adv, new_pos;
    logic [SEG_W-1:0] new_seg;
    logic             seg_adv, new_done;
    logic signed [32:0] d_ax [3];

    assign in_acc   = i_valid && o_ready;
    assign len_zero = (r_len == '0);
    assign sum_ovf  = (r_sum[65:64] != 2'b00);
    assign out_free = !r_out_valid || i_ready;

    // Clamp the waypoint count into the table and take the last segment
    always_comb begin
        cnt_cl = 32'(r_count);
        if (cnt_cl < 32'd2) begin
            cnt_cl = 32'd2;
        end else if (cnt_cl > 32'(MAX_WAYPOINTS)) begin
            cnt_cl = 32'(MAX_WAYPOINTS);
        end
        last_seg = SEG_W'(cnt_cl - 32'd2);
    end

    // Axis differences from the two rows
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d_ax[i] = 33'(signed'(ram_rdata[i*COORD_W +: COORD_W]))
                    - 33'(signed'(r_wa[i*COORD_W +: COORD_W]));
        end
    end

    // Position advance and segment step
    always_comb begin
        pos_sum  = {1'b0, r_pos} + {1'b0, r_step};
        pos_adv  = len_zero ? r_pos : (pos_sum[32] ? '1 : pos_sum[31:0]);
        seg_adv  = (pos_adv >= r_len) && (r_seg < last_seg);
        new_seg  = seg_adv ? r_seg + SEG_W'(1) : r_seg;
        new_pos  = seg_adv ? '0 : pos_adv;
        new_done = (new_pos >= r_len) && (new_seg >= last_seg);
    end

    // Shared multiplier: squares, milli reciprocal, axis velocity products
    always_comb begin
        mul_a = r_mag[r_ax];
        mul_b = {1'b0, r_speed};
        if (r_state == S_SQ_MUL) begin
            mul_b = r_mag[r_ax];
        end else if (r_state == S_MILLI_MUL) begin
            mul_a = milli_src + MILLI_ROUND;
            mul_b = MILLI_RECIP;
        end
    end
    assign mul_p = mul_a * mul_b;

    // Milli scaling source by axis counter
    always_comb begin
        unique case (r_ax)
            2'd0:    milli_src = {1'b0, r_speed};
            2'd1:    milli_src = {1'b0, r_taccel};
            default: milli_src = {1'b0, r_raccel};
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && t_action'(i_action) == ACT_TICK) begin
                    n_state = S_RDA;
                end
            end
            S_RDA:         n_state = S_RDB;
            S_RDB:         n_state = S_DIFF;
            S_DIFF:        n_state = S_SQ_MUL;
            S_SQ_MUL:      n_state = S_SQ_ACC;
            S_SQ_ACC:      n_state = (r_ax == 2'd2) ? S_SQRT_GO : S_SQ_MUL;
            S_SQRT_GO:     n_state = sum_ovf ? S_MILLI_MUL : S_SQRT_WAIT;
            S_SQRT_WAIT:   n_state = sqrt_done ? S_MILLI_MUL : S_SQRT_WAIT;
            S_MILLI_MUL:   n_state = S_MILLI_SCALE;
            S_MILLI_SCALE: n_state = (r_ax == 2'd2) ? S_VEL_MUL : S_MILLI_MUL;
            S_VEL_MUL:     n_state = S_VEL_GO;
            S_VEL_GO: begin
                if (!len_zero) begin
                    n_state = S_VEL_WAIT;
                end else begin
                    n_state = (r_ax == 2'd2) ? S_FIN : S_VEL_MUL;
                end
            end
            S_VEL_WAIT: begin
                if (div_done) begin
                    n_state = (r_ax == 2'd2) ? S_FIN : S_VEL_MUL;
                end
            end
            S_FIN:         n_state = out_free ? S_IDLE : S_FIN;
            default:       n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_ready      = (r_state == S_IDLE);
        ram_raddr    = r_seg;
        ram_we       = 1'b0;
        sqrt_start   = 1'b0;
        div_req      = '0;
        unique case (r_state)
            S_IDLE: begin
                ram_we = in_acc && t_action'(i_action) == ACT_LOAD
                      && (32'(i_wp_index) < 32'(MAX_WAYPOINTS));
            end
            S_RDB:       ram_raddr  = r_seg + SEG_W'(1);
            S_SQRT_GO:   sqrt_start = !sum_ovf;
            S_VEL_GO: begin
                div_req.start    = !len_zero;
                div_req.dividend = r_prod[DIVN_W-1:0];
                div_req.divisor  = r_len;
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_speed     <= '0;
            r_taccel    <= '0;
            r_raccel    <= '0;
            r_count     <= 5'd2;
            r_seg       <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_lastv[i] <= '0;
                r_lastr[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            // Configuration writes
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_PATH_SPEED:  r_speed  <= i_cfg_data;
                    CFG_TRANS_ACCEL: r_taccel <= i_cfg_data;
                    CFG_ROT_ACCEL:   r_raccel <= i_cfg_data;
                    default:         r_count  <= i_cfg_data[4:0];
                endcase
            end
            // Restart and tick-start segment clamp
            if (in_acc) begin
                if (t_action'(i_action) == ACT_RESTART) begin
                    r_seg <= '0;
                    r_pos <= '0;
                end else if (t_action'(i_action) == ACT_TICK && r_seg > last_seg) begin
                    r_seg <= last_seg;
                end
            end
            // Raise valid on a committed tick, drop it once taken
            r_out_valid <= (r_state == S_FIN && out_free) || (r_out_valid && !i_ready);
            // Commit the tick
            if (r_state == S_FIN && out_free) begin
                r_seg       <= new_seg;
                r_pos       <= new_pos;
                for (int i = 0; i < 3; i++) begin
                    r_lastv[i] <= slew(r_target[i], r_lastv[i], r_tlim);
                    r_lastr[i] <= slew('0, r_lastr[i], r_rlim);
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: r_ax <= '0;
            S_RDB:  r_wa <= ram_rdata;
            S_DIFF: begin
                for (int i = 0; i < 3; i++) begin
                    r_neg[i] <= d_ax[i][32];
                    r_mag[i] <= d_ax[i][32] ? 32'(-d_ax[i]) : d_ax[i][31:0];
                end
                r_sum <= '0;
            end
            S_SQ_MUL: r_prod <= mul_p;
            S_SQ_ACC: begin
                r_sum <= r_sum + {2'b00, r_prod};
                r_ax  <= (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
            end
            S_SQRT_GO: begin
                if (sum_ovf) begin
                    r_len <= '1;
                end
            end
            S_SQRT_WAIT: begin
                if (sqrt_done) begin
                    r_len <= sqrt_root;
                end
            end
            S_MILLI_MUL: r_prod <= mul_p;
            S_MILLI_SCALE: begin
                unique case (r_ax)
                    2'd0:    r_step <= 32'(r_prod[63:MILLI_SHIFT]);
                    2'd1:    r_tlim <= 32'(r_prod[63:MILLI_SHIFT]);
                    default: r_rlim <= 32'(r_prod[63:MILLI_SHIFT]);
                endcase
                r_ax <= (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
            end
            S_VEL_MUL: r_prod <= mul_p;
            S_VEL_GO: begin
                if (len_zero) begin
                    r_target[r_ax] <= '0;
                    r_ax <= r_ax + 2'd1;
                end
            end
            S_VEL_WAIT: begin
                if (div_done) begin
                    r_target[r_ax] <= r_neg[r_ax] ? 32'(-{1'b0, div_quot})
                                                  : {1'b0, div_quot};
                    r_ax <= r_ax + 2'd1;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    for (int i = 0; i < 3; i++) begin
                        r_ovel[i]  <= slew(r_target[i], r_lastv[i], r_tlim);
                        r_orate[i] <= slew('0, r_lastr[i], r_rlim);
                    end
                    r_oseg  <= 4'(new_seg);
                    r_odone <= new_done;
                    r_ozero <= len_zero;
                end
            end
            default: begin
            end
        endcase
    end

    wtsl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_WAYPOINTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (SEG_W'(i_wp_index)),
        .i_wdata ({i_wp_z, i_wp_y, i_wp_x}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    wtsl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    wtsl_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_value (r_sum[63:0]),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    assign o_valid        = r_out_valid;
    assign o_vel_x        = r_ovel[0];
    assign o_vel_y        = r_ovel[1];
    assign o_vel_z        = r_ovel[2];
    assign o_rate_x       = r_orate[0];
    assign o_rate_y       = r_orate[1];
    assign o_rate_z       = r_orate[2];
    assign o_segment      = r_oseg;
    assign o_path_done    = r_odone;
    assign o_zero_segment = r_ozero;
endmodule

// ===== test/tb_waypoint_twist_slew_limiter_unit.sv =====
// Self-checking testbench for waypoint_twist_slew_limiter_unit: directed table, then random
// path-following phases under several register settings, checked against a local predictor.
// Depends on wtsl_pkg and the design files of the block.
module tb_waypoint_twist_slew_limiter_unit;
    import wtsl_pkg::*;

    localparam int unsigned SLOTS      = MAX_WAYPOINTS_DEF;
    localparam int unsigned IDLE_LIMIT = 20000;
    localparam int unsigned DRAIN_WAIT = 300;
    localparam int unsigned PHASES     = 7;
    localparam int unsigned PHASE_ITEMS = 190;

    typedef struct packed {
        logic signed [31:0] vx, vy, vz, rx, ry, rz;
        logic [3:0]         seg;
        logic               done;
        logic               zs;
    } twist_t;

    typedef struct {
        t_action     act;
        logic [3:0]  idx;
        logic [31:0] x, y, z;
        bit          fixed;
    } stim_row_t;

    logic        i_clk, i_rst_n;
    logic        i_valid, o_ready;
    logic [1:0]  i_action;
    logic [3:0]  i_wp_index;
    logic signed [31:0] i_wp_x, i_wp_y, i_wp_z;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic signed [31:0] o_vel_x, o_vel_y, o_vel_z, o_rate_x, o_rate_y, o_rate_z;
    logic [3:0]  o_segment;
    logic        o_path_done, o_zero_segment;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;

    waypoint_twist_slew_limiter_unit dut (.*);

    // Predictor state
    logic [31:0]  wp_mem [SLOTS*3];
    int unsigned  seg_idx;
    logic [31:0]  path_pos;
    longint       lin_last [3];
    longint       ang_last [3];
    logic [30:0]  cfg_speed, cfg_tacc, cfg_racc;
    logic [4:0]   cfg_count;

    twist_t       pending_twists [$];
    int unsigned  mismatches = 0;
    int unsigned  idle_cycles = 0;
    int unsigned  stall_left = 0;
    int unsigned  calm_left = 0;
    bit           no_idle;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint unsigned milli(longint unsigned v);
        return (v + 64'd500) / 64'd1000;
    endfunction

    function automatic longint unsigned isqrt64(longint unsigned s);
        longint unsigned r, b;
        r = 0;
        b = 64'h1 << 62;
        while (b > s) b >>= 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint slew(longint target, longint last, longint unsigned lim);
        longint diff;
        longint unsigned mag;
        diff = target - last;
        mag = diff < 0 ? longint'(-diff) : diff;
        if (mag > lim) return diff < 0 ? last - longint'(lim) : last + longint'(lim);
        return target;
    endfunction

    // Advance the path by one tick and form the limited twist
    function automatic twist_t predict_tick();
        twist_t t;
        int unsigned last_seg, n;
        logic signed [31:0] ca, cb;
        longint d [3];
        longint tgt [3];
        longint a, b, v;
        longint unsigned m, len, pos;
        logic [65:0] total;
        bit zero, done;
        n = cfg_count < 2 ? 2 : (cfg_count > SLOTS ? SLOTS : cfg_count);
        last_seg = n - 2;
        if (seg_idx > last_seg) seg_idx = last_seg;
        total = '0;
        for (int i = 0; i < 3; i++) begin
            ca = wp_mem[seg_idx*3 + i];
            cb = wp_mem[(seg_idx+1)*3 + i];
            a = ca;
            b = cb;
            d[i] = b - a;
            m = d[i] < 0 ? longint'(-d[i]) : d[i];
            total += 66'(m * m);
        end
        len = total[65:64] != 0 ? 64'hFFFF_FFFF : isqrt64(total[63:0]);
        zero = (len == 0);
        for (int i = 0; i < 3; i++) begin
            if (zero) begin
                tgt[i] = 0;
            end else begin
                m = d[i] < 0 ? longint'(-d[i]) : d[i];
                v = (m * longint'(cfg_speed)) / len;
                tgt[i] = d[i] < 0 ? -v : v;
            end
        end
        pos = path_pos;
        if (!zero) begin
            pos += milli(cfg_speed);
            if (pos > 64'hFFFF_FFFF) pos = 64'hFFFF_FFFF;
        end
        if (pos >= len && seg_idx < last_seg) begin
            seg_idx++;
            pos = 0;
        end
        path_pos = pos[31:0];
        done = (pos >= len) && (seg_idx >= last_seg);
        for (int i = 0; i < 3; i++) begin
            lin_last[i] = slew(tgt[i], lin_last[i], milli(cfg_tacc));
            ang_last[i] = slew(0, ang_last[i], milli(cfg_racc));
        end
        t.vx = lin_last[0][31:0];
        t.vy = lin_last[1][31:0];
        t.vz = lin_last[2][31:0];
        t.rx = ang_last[0][31:0];
        t.ry = ang_last[1][31:0];
        t.rz = ang_last[2][31:0];
        t.seg = seg_idx[3:0];
        t.done = done;
        t.zs = zero;
        return t;
    endfunction

    // Apply one accepted request to the predictor; returns 1 when a result follows
    function automatic bit predict_request(t_action act, logic [3:0] idx,
                                           logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                           output twist_t t);
        t = '0;
        case (act)
            ACT_LOAD: begin
                wp_mem[idx*3]     = x;
                wp_mem[idx*3 + 1] = y;
                wp_mem[idx*3 + 2] = z;
            end
            ACT_RESTART: begin
                seg_idx = 0;
                path_pos = '0;
            end
            ACT_TICK: begin
                t = predict_tick();
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 30);
        return $urandom_range(60, 200);
    endfunction

    // Present one request, hold it until accepted, then predict and sometimes idle
    task automatic send(t_action act, logic [3:0] idx, logic [31:0] x, logic [31:0] y,
                        logic [31:0] z, bit fixed, twist_t fixed_twist);
        twist_t t;
        int unsigned gap;
        i_valid    <= 1'b1;
        i_action   <= act;
        i_wp_index <= idx;
        i_wp_x     <= x;
        i_wp_y     <= y;
        i_wp_z     <= z;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (predict_request(act, idx, x, y, z, t))
            pending_twists.push_back(fixed ? fixed_twist : t);
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every pending result has arrived
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_twists.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_index idx, logic [30:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_PATH_SPEED:  cfg_speed = data;
            CFG_TRANS_ACCEL: cfg_tacc  = data;
            CFG_ROT_ACCEL:   cfg_racc  = data;
            default:         cfg_count = data[4:0];
        endcase
    endtask

    task automatic configure(logic [30:0] speed, logic [30:0] tacc, logic [30:0] racc,
                             logic [4:0] count);
        drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        cfg_write(CFG_PATH_SPEED, speed);
        cfg_write(CFG_TRANS_ACCEL, tacc);
        cfg_write(CFG_ROT_ACCEL, racc);
        cfg_write(CFG_WP_COUNT, 31'(count));
        i_cfg_we <= 1'b0;
    endtask

    // Result check, receiver stalls and watchdog
    always @(posedge i_clk) begin
        twist_t got, want;
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            if (o_valid && i_ready) begin
                got = '{o_vel_x, o_vel_y, o_vel_z, o_rate_x, o_rate_y, o_rate_z,
                        o_segment, o_path_done, o_zero_segment};
                if (pending_twists.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %p", got);
                end else begin
                    want = pending_twists.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p got %p", want, got);
                    end
                end
            end
        end
        // Stall the receiver in bursts, with calm stretches between them
        if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            i_ready <= 1'b1;
            if (calm_left > 0) begin
                calm_left <= calm_left - 1;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: stall_left <= 0;
                    5, 6, 7:       stall_left <= $urandom_range(1, 3);
                    8:             stall_left <= $urandom_range(4, 20);
                    default:       stall_left <= ($urandom_range(0, 3) == 0) ?
                                                 $urandom_range(100, 400) : 0;
                endcase
                if ($urandom_range(0, 15) == 0) calm_left <= 500;
            end
        end
    end

    initial begin
        stim_row_t   rows [19];
        logic [31:0] path_pt [SLOTS][3];
        twist_t      zero_twist, none;
        logic [30:0] sp, ta, ra;
        logic [4:0]  cnt;
        longint      pt, dlt;
        longint unsigned span;
        int unsigned r, sl;
        logic [31:0] cx;

        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_action    <= ACT_NONE;
        i_wp_index  <= '0;
        i_wp_x      <= '0;
        i_wp_y      <= '0;
        i_wp_z      <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_PATH_SPEED;
        i_cfg_data  <= '0;
        no_idle     = 1'b0;
        none        = '0;
        cfg_speed = '0; cfg_tacc = '0; cfg_racc = '0; cfg_count = 5'd2;
        seg_idx = 0; path_pos = '0;
        for (int i = 0; i < 3; i++) begin
            lin_last[i] = 0;
            ang_last[i] = 0;
        end
        for (int i = 0; i < SLOTS*3; i++) wp_mem[i] = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Load every slot so that no tick reads an unwritten row
        for (int s = 0; s < SLOTS; s++) send(ACT_LOAD, s[3:0], 0, 0, 0, 1'b0, none);
        configure(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 5'd16);

        // Directed: zero segment, saturated length, extremes, unknown action, restart.
        // A zero-length first segment moves the path on to segment one.
        zero_twist = '{0, 0, 0, 0, 0, 0, 4'd1, 1'b0, 1'b1};
        rows = '{
            '{ACT_TICK,    4'd0,  32'h0,         32'h0,         32'h0,         1'b1},
            '{ACT_LOAD,    4'd2,  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0},
            '{ACT_LOAD,    4'd1,  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0},
            '{ACT_TICK,    4'd0,  32'h0,         32'h0,         32'h0,         1'b0},
            '{ACT_LOAD,    4'd2,  32'h0,         32'h0,         32'h0,         1'b0},
            '{ACT_LOAD,    4'd1,  32'h8000_0000, 32'h7FFF_FFFF, 32'h0,         1'b0},
            '{ACT_TICK,    4'd0,  32'h0,         32'h0,         32'h0,         1'b0},
            '{ACT_NONE,    4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0},
            '{ACT_TICK,    4'd0,  32'h0,         32'h0,         32'h0,         1'b0},
            '{ACT_RESTART, 4'd0,  32'h0,         32'h0,         32'h0,         1'b0},
            '{ACT_TICK,    4'd0,  32'h0,         32'h0,         32'h0,         1'b0},
            '{ACT_LOAD,    4'd0,  32'h0,         32'h0,         32'h0,         1'b0},
            '{ACT_LOAD,    4'd1,  32'h0,         32'h0,         32'h0,         1'b0},
            '{ACT_LOAD,    4'd2,  32'h0001_0000, 32'hFFFF_0000, 32'h0,         1'b0},
            '{ACT_RESTART, 4'd0,  32'h0,         32'h0,         32'h0,         1'b0},
            '{ACT_TICK,    4'd0,  32'h0,         32'h0,         32'h0,         1'b0},
            '{ACT_TICK,    4'd0,  32'h0,         32'h0,         32'h0,         1'b0},
            '{ACT_LOAD,    4'd15, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0},
            '{ACT_TICK,    4'd0,  32'h0,         32'h0,         32'h0,         1'b0}
        };
        foreach (rows[i])
            send(rows[i].act, rows[i].idx, rows[i].x, rows[i].y, rows[i].z,
                 rows[i].fixed, zero_twist);

        // Random phases; phases zero, two, four and six shrink the chain without a restart
        for (int ph = 0; ph < PHASES; ph++) begin
            sp = 31'($urandom_range(0, 32'h0040_0000));
            ta = 31'($urandom_range(0, 32'h0010_0000));
            ra = 31'($urandom_range(0, 32'h0000_1000));
            case (ph)
                0: begin sp = 31'h0002_0000; cnt = 5'd4; end
                1: begin ta = 31'h0; ra = 31'h0; cnt = 5'd16; end
                2: begin sp = 31'h0; cnt = 5'd0; end
                3: begin ta = 31'h7FFF_FFFF; cnt = 5'd31; end
                4: begin cnt = 5'd1; end
                5: begin ra = 31'h7FFF_FFFF; cnt = 5'd17; end
                default: begin cnt = 5'd3; end
            endcase
            configure(sp, ta, ra, cnt);

            // Lay out a path whose segment deltas span up to ten ticks of advance per axis
            span = milli(sp) * 10 + 1;
            if (span > 64'h4000_0000) span = 64'h4000_0000;
            for (int k = 0; k < 3; k++) begin
                pt = longint'($urandom_range(0, 32'h0200_0000)) - 64'h0100_0000;
                for (int s = 0; s < SLOTS; s++) begin
                    path_pt[s][k] = pt[31:0];
                    dlt = longint'($urandom_range(0, 32'(span)));
                    if ($urandom_range(0, 1)) dlt = -dlt;
                    if ($urandom_range(0, 7) == 0) dlt = 0;
                    pt += dlt;
                end
            end
            for (int s = 0; s < SLOTS; s++)
                send(ACT_LOAD, s[3:0], path_pt[s][0], path_pt[s][1], path_pt[s][2],
                     1'b0, none);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
                // Hold off the sender until the block has caught up
                if (n == PHASE_ITEMS / 2) drain();
                r  = $urandom_range(0, 99);
                sl = $urandom_range(0, SLOTS - 1);
                cx = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
                if (r < 70)
                    send(ACT_TICK, 4'($urandom()), $urandom(), $urandom(), $urandom(),
                         1'b0, none);
                else if (r < 82)
                    send(ACT_LOAD, sl[3:0], path_pt[sl][0], path_pt[sl][1], path_pt[sl][2],
                         1'b0, none);
                else if (r < 88)
                    send(ACT_LOAD, sl[3:0], $urandom(), $urandom(), $urandom(), 1'b0, none);
                else if (r < 94)
                    send(ACT_RESTART, 4'($urandom()), $urandom(), $urandom(), $urandom(),
                         1'b0, none);
                else if (r < 97)
                    send(ACT_NONE, 4'($urandom()), $urandom(), $urandom(), $urandom(),
                         1'b0, none);
                else
                    send(ACT_LOAD, sl[3:0], cx, ~cx, cx, 1'b0, none);
            end
        end

        drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0 && pending_twists.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
